// ===== src/skng_pkg.sv =====
// Shared types, constants and register map of the soft-knee noise gate.
package skng_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 16;

    // Configuration port geometry: six 32-bit registers at byte addresses 4*i.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register reset values at the default widths.
    localparam int THRESHOLD_RST   = 262144;
    localparam int FLOOR_GAIN_RST  = 6554;
    localparam int ENV_ATTACK_RST  = 64186;
    localparam int ENV_RELEASE_RST = 65508;
    localparam int GAIN_ATTACK_RST = 65263;
    localparam int GAIN_RELEASE_RST = 65522;

    typedef enum logic [2:0] {
        REG_THRESHOLD    = 3'd0,
        REG_FLOOR_GAIN   = 3'd1,
        REG_ENV_ATTACK   = 3'd2,
        REG_ENV_RELEASE  = 3'd3,
        REG_GAIN_ATTACK  = 3'd4,
        REG_GAIN_RELEASE = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV_MUL,
        ST_ENV_UPD,
        ST_KNEE,
        ST_DIV,
        ST_SQ_MUL,
        ST_SS_MUL,
        ST_TG_MUL,
        ST_TG_UPD,
        ST_G_MUL,
        ST_G_UPD,
        ST_O_MUL,
        ST_FIN
    } t_state;

endpackage

// ===== src/skng_mul.sv =====
// Shared signed multiplier with a registered product.
module skng_mul #(
    parameter int A_W = 25,
    parameter int B_W = 19
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [A_W-1:0]     i_a,
    input  logic signed [B_W-1:0]     i_b,
    output logic signed [A_W+B_W-1:0] o_prod
);

    logic signed [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== src/skng_div.sv =====
// Restoring divider that yields one quotient bit per cycle for a fraction below one.
module skng_div #(
    parameter int NUM_W = 23,
    parameter int Q_W   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [NUM_W-1:0] i_den,
    output logic             o_busy,
    output logic [Q_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_den;
    logic [Q_W-1:0]   r_quot;
    logic [NUM_W:0]   w_rem2;
    logic [NUM_W:0]   w_diff;
    logic             w_fit;

    // The numerator is always below the denominator, so the partial remainder
    // stays below the denominator after every step.
    assign w_rem2 = {r_rem, 1'b0};
    assign w_fit  = (w_rem2 >= {1'b0, r_den});
    assign w_diff = w_rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(Q_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= w_fit ? w_diff[NUM_W-1:0] : w_rem2[NUM_W-1:0];
            r_quot <= {r_quot[Q_W-2:0], w_fit};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

// ===== src/skng_cfg.sv =====
// APB register file holding threshold, floor gain and the four filter poles.
module skng_cfg #(
    parameter int SAMPLE_BITS = skng_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = skng_pkg::COEF_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [skng_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [skng_pkg::APB_DATA_W-1:0] pwdata,
    output logic [skng_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [SAMPLE_BITS-2:0]          o_threshold,
    output logic [COEF_BITS:0]              o_floor_gain,
    output logic [COEF_BITS-1:0]            o_env_attack,
    output logic [COEF_BITS-1:0]            o_env_release,
    output logic [COEF_BITS-1:0]            o_gain_attack,
    output logic [COEF_BITS-1:0]            o_gain_release
);

    localparam int TW = SAMPLE_BITS - 1;
    localparam int C  = COEF_BITS;
    localparam int DW = skng_pkg::APB_DATA_W;

    logic [TW-1:0] r_threshold;
    logic [C:0]    r_floor_gain;
    logic [C-1:0]  r_env_attack;
    logic [C-1:0]  r_env_release;
    logic [C-1:0]  r_gain_attack;
    logic [C-1:0]  r_gain_release;

    skng_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign w_idx = skng_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= TW'(skng_pkg::THRESHOLD_RST);
            r_floor_gain   <= (C+1)'(skng_pkg::FLOOR_GAIN_RST);
            r_env_attack   <= C'(skng_pkg::ENV_ATTACK_RST);
            r_env_release  <= C'(skng_pkg::ENV_RELEASE_RST);
            r_gain_attack  <= C'(skng_pkg::GAIN_ATTACK_RST);
            r_gain_release <= C'(skng_pkg::GAIN_RELEASE_RST);
        end else if (w_wr) begin
            case (w_idx)
                skng_pkg::REG_THRESHOLD:    r_threshold    <= pwdata[TW-1:0];
                skng_pkg::REG_FLOOR_GAIN:   r_floor_gain   <= pwdata[C:0];
                skng_pkg::REG_ENV_ATTACK:   r_env_attack   <= pwdata[C-1:0];
                skng_pkg::REG_ENV_RELEASE:  r_env_release  <= pwdata[C-1:0];
                skng_pkg::REG_GAIN_ATTACK:  r_gain_attack  <= pwdata[C-1:0];
                skng_pkg::REG_GAIN_RELEASE: r_gain_release <= pwdata[C-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            skng_pkg::REG_THRESHOLD:    prdata = DW'(r_threshold);
            skng_pkg::REG_FLOOR_GAIN:   prdata = DW'(r_floor_gain);
            skng_pkg::REG_ENV_ATTACK:   prdata = DW'(r_env_attack);
            skng_pkg::REG_ENV_RELEASE:  prdata = DW'(r_env_release);
            skng_pkg::REG_GAIN_ATTACK:  prdata = DW'(r_gain_attack);
            skng_pkg::REG_GAIN_RELEASE: prdata = DW'(r_gain_release);
            default:                    prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign o_threshold    = r_threshold;
    assign o_floor_gain   = r_floor_gain;
    assign o_env_attack   = r_env_attack;
    assign o_env_release  = r_env_release;
    assign o_gain_attack  = r_gain_attack;
    assign o_gain_release = r_gain_release;

endmodule

// ===== src/soft_knee_noise_gate_unit.sv =====
// Top level of the soft-knee noise gate: sequencer, state and datapath around shared units.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: sample_in; tuser: sample_invalid
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: sample_out; tuser: passed_invalid
//  apb       in         psel/penable/pwrite/pready   six registers at byte address 4*i
//
// A new sample is taken only once the last one is done. A sample inside the knee passes
// the divider, which produces one quotient bit per cycle; a sample outside the knee skips
// it and an invalid sample skips all filtering. All products go through one multiplier.
// Reset is synchronous: the envelope clears and the gain loads the saturated floor reset.
// A result waits in the output register while the next sample is worked on; the block
// holds its last step only if that register is still full when the next result is due.
module soft_knee_noise_gate_unit #(
    parameter int SAMPLE_BITS = skng_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = skng_pkg::COEF_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // tdata: sample_in [SAMPLE_BITS-1:0], zero padding above
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: sample_invalid [0]
    input  logic                                    s_axis_tuser,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: sample_out [SAMPLE_BITS-1:0], zero padding above
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser: passed_invalid [0]
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [skng_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [skng_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [skng_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);

    localparam int S       = SAMPLE_BITS;
    localparam int C       = COEF_BITS;
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int MA      = (S + 1 > C + 2) ? S + 1 : C + 2;
    localparam int MB      = C + 3;
    localparam int P       = MA + MB;

    localparam logic [C:0]   UNITY     = (C+1)'(1) << C;
    localparam logic [C+1:0] THREE_U   = (C+2)'(3) << C;
    localparam logic [P-1:0] HALF      = P'(1) << (C - 1);
    localparam logic [C-1:0] C_ZERO    = '0;
    localparam logic [C:0]   FLOOR_RST = (C+1)'(skng_pkg::FLOOR_GAIN_RST);
    localparam logic [C:0]   GAIN_RST  = (FLOOR_RST > UNITY) ? UNITY : FLOOR_RST;

    // Configuration.
    logic [S-2:0] w_threshold;
    logic [C:0]   w_floor_cfg;
    logic [C-1:0] w_env_attack;
    logic [C-1:0] w_env_release;
    logic [C-1:0] w_gain_attack;
    logic [C-1:0] w_gain_release;

    skng_cfg #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_threshold    (w_threshold),
        .o_floor_gain   (w_floor_cfg),
        .o_env_attack   (w_env_attack),
        .o_env_release  (w_env_release),
        .o_gain_attack  (w_gain_attack),
        .o_gain_release (w_gain_release)
    );

    // Sequencer and datapath registers.
    skng_pkg::t_state r_state;
    skng_pkg::t_state n_state;

    logic signed [S-1:0] r_x;
    logic                r_inv;
    logic [S-1:0]        r_env;
    logic [C:0]          r_gain;
    logic [C:0]          r_target;
    logic                r_out_valid;
    logic [S-1:0]        r_out_data;
    logic                r_out_user;

    // Combinational datapath terms.
    logic                w_accept;
    logic [C:0]          w_floor;
    logic [S-1:0]        w_mag;
    logic signed [S:0]   w_env_d;
    logic [C-1:0]        w_env_c;
    logic signed [C+1:0] w_gain_d;
    logic [C-1:0]        w_gain_c;
    logic [S-2:0]        w_knee;
    logic                w_below_knee;
    logic                w_above_thr;
    logic [S-2:0]        w_num;
    logic [S-2:0]        w_den;
    logic [C+1:0]        w_3u2x;
    logic signed [P-1:0] w_prod;
    logic signed [P-1:0] w_env_sum;
    logic signed [P-1:0] w_gain_sum;
    logic signed [P-1:0] w_out_sum;
    logic [C-1:0]        w_quot;
    logic                w_div_busy;
    logic                w_out_free;

    // Sequencer outputs.
    logic                 w_mul_en;
    logic signed [MA-1:0] w_mul_a;
    logic signed [MB-1:0] w_mul_b;
    logic                 w_div_start;
    logic                 w_env_we;
    logic                 w_tgt_we;
    logic [C:0]           w_tgt_next;
    logic                 w_gain_we;
    logic                 w_out_load;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_floor    = (w_floor_cfg > UNITY) ? UNITY : w_floor_cfg;

    // Magnitude as an unsigned value; the most negative sample maps to 2^(S-1).
    assign w_mag   = r_x[S-1] ? (~r_x + 1'b1) : r_x;
    assign w_env_d = $signed({1'b0, r_env}) - $signed({1'b0, w_mag});
    assign w_env_c = (w_mag > r_env) ? w_env_attack : w_env_release;

    assign w_gain_d = $signed({1'b0, r_gain}) - $signed({1'b0, r_target});
    assign w_gain_c = (r_target > r_gain) ? w_gain_attack : w_gain_release;

    // The knee test comes first so that a tiny threshold never reaches the divider.
    assign w_knee       = w_threshold >> 1;
    assign w_below_knee = (r_env <= S'(w_knee));
    assign w_above_thr  = (r_env >= S'(w_threshold));
    assign w_num        = (S-1)'(r_env - S'(w_knee));
    assign w_den        = w_threshold - w_knee;

    assign w_3u2x = THREE_U - {1'b0, w_quot, 1'b0};

    // A one-pole step c*old + (1-c)*in is formed as in + c*(old - in).
    assign w_env_sum  = $signed(P'({w_mag, C_ZERO})) + w_prod + $signed(HALF);
    assign w_gain_sum = $signed(P'({r_target, C_ZERO})) + w_prod + $signed(HALF);
    assign w_out_sum  = w_prod + $signed(HALF);

    skng_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    skng_div #(
        .NUM_W (S - 1),
        .Q_W   (C)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            skng_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = s_axis_tuser ? skng_pkg::ST_FIN : skng_pkg::ST_ENV_MUL;
                end
            end
            skng_pkg::ST_ENV_MUL: n_state = skng_pkg::ST_ENV_UPD;
            skng_pkg::ST_ENV_UPD: n_state = skng_pkg::ST_KNEE;
            skng_pkg::ST_KNEE: begin
                if (w_below_knee || w_above_thr) begin
                    n_state = skng_pkg::ST_G_MUL;
                end else begin
                    n_state = skng_pkg::ST_DIV;
                end
            end
            skng_pkg::ST_DIV: begin
                if (!w_div_busy) begin
                    n_state = skng_pkg::ST_SQ_MUL;
                end
            end
            skng_pkg::ST_SQ_MUL: n_state = skng_pkg::ST_SS_MUL;
            skng_pkg::ST_SS_MUL: n_state = skng_pkg::ST_TG_MUL;
            skng_pkg::ST_TG_MUL: n_state = skng_pkg::ST_TG_UPD;
            skng_pkg::ST_TG_UPD: n_state = skng_pkg::ST_G_MUL;
            skng_pkg::ST_G_MUL:  n_state = skng_pkg::ST_G_UPD;
            skng_pkg::ST_G_UPD:  n_state = skng_pkg::ST_O_MUL;
            skng_pkg::ST_O_MUL:  n_state = skng_pkg::ST_FIN;
            skng_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = skng_pkg::ST_IDLE;
                end
            end
            default: n_state = skng_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: operand selection for the shared units and write enables.
    always_comb begin
        w_mul_en    = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_env_we    = 1'b0;
        w_tgt_we    = 1'b0;
        w_tgt_next  = UNITY;
        w_gain_we   = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            skng_pkg::ST_ENV_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = MA'(w_env_d);
                w_mul_b  = $signed(MB'(w_env_c));
            end
            skng_pkg::ST_ENV_UPD: begin
                w_env_we = 1'b1;
            end
            skng_pkg::ST_KNEE: begin
                if (w_below_knee) begin
                    w_tgt_we   = 1'b1;
                    w_tgt_next = w_floor;
                end else if (w_above_thr) begin
                    w_tgt_we   = 1'b1;
                    w_tgt_next = UNITY;
                end else begin
                    w_div_start = 1'b1;
                end
            end
            skng_pkg::ST_SQ_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed(MA'(w_quot));
                w_mul_b  = $signed(MB'(w_quot));
            end
            skng_pkg::ST_SS_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed(MA'(w_prod[C +: C]));
                w_mul_b  = $signed(MB'(w_3u2x));
            end
            skng_pkg::ST_TG_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed(MA'(w_prod[C +: C+1]));
                w_mul_b  = $signed(MB'(UNITY - w_floor));
            end
            skng_pkg::ST_TG_UPD: begin
                w_tgt_we   = 1'b1;
                w_tgt_next = w_floor + w_prod[C +: C+1];
            end
            skng_pkg::ST_G_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = MA'(w_gain_d);
                w_mul_b  = $signed(MB'(w_gain_c));
            end
            skng_pkg::ST_G_UPD: begin
                w_gain_we = 1'b1;
            end
            skng_pkg::ST_O_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = MA'(r_x);
                w_mul_b  = $signed(MB'(r_gain));
            end
            skng_pkg::ST_FIN: begin
                w_out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skng_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Filter state: an invalid sample clears the envelope and drops the gain to the floor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env  <= '0;
            r_gain <= GAIN_RST;
        end else if (w_accept && s_axis_tuser) begin
            r_env  <= '0;
            r_gain <= w_floor;
        end else begin
            if (w_env_we) begin
                r_env <= w_env_sum[C +: S];
            end
            if (w_gain_we) begin
                r_gain <= w_gain_sum[C +: C+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x   <= $signed(s_axis_tdata[S-1:0]);
            r_inv <= s_axis_tuser;
        end
        if (w_tgt_we) begin
            r_target <= w_tgt_next;
        end
    end

    // Output register; taking the bits above the binary point of the rounded
    // product gives the floor of the quotient for either sign.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= r_inv ? r_x : w_out_sum[C +: S];
            r_out_user <= r_inv;
        end
    end

    assign s_axis_tready = (r_state == skng_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_data);
    assign m_axis_tuser  = r_out_user;

    a_gain_le_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= UNITY)
        else $error("smoothed gain above unity");

    a_env_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= (S'(1) << (S - 1)))
        else $error("envelope above full scale");

    a_invalid_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser) |=> (r_env == '0 && r_state == skng_pkg::ST_FIN))
        else $error("invalid sample did not clear the envelope");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == skng_pkg::ST_DIV))
        else $error("divider busy outside its state");

    a_target_le_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skng_pkg::ST_G_MUL) |-> (r_target <= UNITY))
        else $error("target gain above unity");

endmodule

// ===== tb/sv/soft_knee_noise_gate_unit_tb.sv =====
// Self-checking testbench for the soft-knee noise gate: directed table, then randomized phases.
`timescale 1ns / 1ps

module soft_knee_noise_gate_unit_tb;

    localparam int SMP_W  = skng_pkg::SAMPLE_BITS_DEF;
    localparam int CF_W   = skng_pkg::COEF_BITS_DEF;
    localparam int ADDR_W = skng_pkg::APB_ADDR_W;
    localparam int DATA_W = skng_pkg::APB_DATA_W;
    localparam longint unsigned UNITY = 64'd1 << CF_W;
    localparam longint unsigned HALF  = 64'd1 << (CF_W - 1);
    localparam int REG_UNMAPPED_LO = 6;
    localparam int REG_UNMAPPED_HI = 7;
    localparam int NUM_ROWS = 30;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 150;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic             passed;
    } t_gated;

    typedef struct packed {
        t_row_kind        kind;
        logic [2:0]       idx;
        logic [31:0]      value;
        logic [SMP_W-1:0] sample;
        logic             inv;
        logic             typed;
        logic [SMP_W-1:0] exp_sample;
        logic             exp_passed;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic [SMP_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [SMP_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    // Mirror of the configuration and of the gate state.
    logic [22:0] thr_r      = 23'(skng_pkg::THRESHOLD_RST);
    logic [16:0] floor_r    = 17'(skng_pkg::FLOOR_GAIN_RST);
    logic [15:0] env_att_r  = 16'(skng_pkg::ENV_ATTACK_RST);
    logic [15:0] env_rel_r  = 16'(skng_pkg::ENV_RELEASE_RST);
    logic [15:0] gain_att_r = 16'(skng_pkg::GAIN_ATTACK_RST);
    logic [15:0] gain_rel_r = 16'(skng_pkg::GAIN_RELEASE_RST);
    logic [SMP_W-1:0] env_lvl = '0;
    logic [16:0] gain_lvl = 17'(skng_pkg::FLOOR_GAIN_RST);

    t_gated pending_gated[$];
    t_row steps [NUM_ROWS];
    int mismatch_count = 0;
    int gated_seen = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit long_hold_done = 1'b0;

    soft_knee_noise_gate_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("soft_knee_noise_gate_unit_tb: errors");
        $finish;
    end

    function automatic longint unsigned floor_sat();
        return (longint'(floor_r) > UNITY) ? UNITY : longint'(floor_r);
    endfunction

    function automatic longint unsigned one_pole(input logic [15:0] c,
                                                 input longint unsigned prev,
                                                 input longint unsigned target);
        longint unsigned cc;
        cc = longint'(c);
        return (cc * prev + (UNITY - cc) * target + HALF) >> CF_W;
    endfunction

    // Advances the gate state by one sample and returns the gated output.
    function automatic t_gated gate_sample(input logic [SMP_W-1:0] raw, input logic inv);
        t_gated res;
        longint signed xs, prod;
        longint unsigned mag, env, fl, knee, pos, sq, curve, target;
        logic [15:0] c;
        xs = longint'($signed(raw));
        if (inv) begin
            env_lvl = '0;
            gain_lvl = 17'(floor_sat());
            res.sample = raw;
            res.passed = 1'b1;
            return res;
        end
        mag = (xs < 0) ? longint'(-xs) : longint'(xs);
        c = (mag > longint'(env_lvl)) ? env_att_r : env_rel_r;
        env = one_pole(c, longint'(env_lvl), mag);
        env_lvl = SMP_W'(env);

        fl = floor_sat();
        knee = longint'(thr_r) >> 1;
        if (env <= knee) begin
            target = fl;
        end else if (env >= longint'(thr_r)) begin
            target = UNITY;
        end else begin
            pos = ((env - knee) << CF_W) / (longint'(thr_r) - knee);
            sq = (pos * pos) >> CF_W;
            curve = (sq * (3 * UNITY - 2 * pos)) >> CF_W;
            target = fl + (((UNITY - fl) * curve) >> CF_W);
        end

        c = (target > longint'(gain_lvl)) ? gain_att_r : gain_rel_r;
        gain_lvl = 17'(one_pole(c, longint'(gain_lvl), target));

        prod = xs * longint'(gain_lvl) + longint'(HALF);
        res.sample = SMP_W'(prod >>> CF_W);
        res.passed = 1'b0;
        return res;
    endfunction

    function automatic logic [31:0] add_junk(input logic [31:0] v, input int w);
        logic [31:0] hi;
        hi = $urandom;
        hi = hi & ~((32'd1 << w) - 32'd1);
        return ($urandom_range(0, 1) == 1) ? (v | hi) : v;
    endfunction

    function automatic logic [31:0] pick_coef();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = 32'd0;
            1: v = 32'd65535;
            2: v = $urandom_range(60000, 65535);
            default: v = $urandom_range(0, 65535);
        endcase
        return add_junk(v, 16);
    endfunction

    task automatic write_reg(input int idx, input logic [31:0] val);
        logic [ADDR_W-1:0] addr;
        addr = ADDR_W'(idx * 4);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            skng_pkg::REG_THRESHOLD:    thr_r = val[22:0];
            skng_pkg::REG_FLOOR_GAIN:   floor_r = val[16:0];
            skng_pkg::REG_ENV_ATTACK:   env_att_r = val[15:0];
            skng_pkg::REG_ENV_RELEASE:  env_rel_r = val[15:0];
            skng_pkg::REG_GAIN_ATTACK:  gain_att_r = val[15:0];
            skng_pkg::REG_GAIN_RELEASE: gain_rel_r = val[15:0];
            default: ;
        endcase
    endtask

    // Stops offering samples and waits until every gated sample has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_gated.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [SMP_W-1:0] smp, input logic inv,
                               input bit typed, input t_gated typed_res);
        t_gated predicted;
        while (tx_idle_on && $urandom_range(0, 99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata <= smp;
        s_axis_tuser <= inv;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = gate_sample(smp, inv);
        pending_gated.push_back(typed ? typed_res : predicted);
    endtask

    // Output side: random back-pressure plus one long hold-off that fills the block.
    initial begin
        forever begin
            if (!long_hold_done && gated_seen >= 400) begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < 13);
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_out
        t_gated head;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            gated_seen <= gated_seen + 1;
            if (pending_gated.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected transaction, expected none, actual sample %h flag %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                head = pending_gated.pop_front();
                if (m_axis_tdata !== head.sample) begin
                    mismatch_count++;
                    $display("%0t: sample_out mismatch, expected %h, actual %h",
                             $time, head.sample, m_axis_tdata);
                end
                if (m_axis_tuser !== head.passed) begin
                    mismatch_count++;
                    $display("%0t: passed_invalid mismatch, expected %b, actual %b",
                             $time, head.passed, m_axis_tuser);
                end
            end
        end
    end

    initial begin
        int amp, lim, pick, thr_v;
        bit loud;
        logic [SMP_W-1:0] smp;
        logic inv;
        logic [31:0] val;

        //  kind, idx, value, sample, inv, typed, expected sample, expected flag
        steps = '{
            '{ROW_ITEM, 3'd0, 32'h0, 24'h000000, 1'b0, 1'b1, 24'h000000, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h7FFFFF, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h800000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h7FFFFF, 1'b1, 1'b1, 24'h7FFFFF, 1'b1},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h800000, 1'b1, 1'b1, 24'h800000, 1'b1},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h000001, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'hFFFFFF, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_WRITE, skng_pkg::REG_ENV_ATTACK, 32'h0, 24'h0, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h030000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'hFC0000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h018000, 1'b0, 1'b0, 24'h0, 1'b0},
            // Floor above unity saturates; the invalid sample loads it into the gain.
            '{ROW_WRITE, skng_pkg::REG_FLOOR_GAIN, 32'hFFFFFFFF, 24'h0, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h123456, 1'b1, 1'b1, 24'h123456, 1'b1},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h400000, 1'b0, 1'b0, 24'h0, 1'b0},
            // Degenerate thresholds: the knee test must avoid the division.
            '{ROW_WRITE, skng_pkg::REG_THRESHOLD, 32'h0, 24'h0, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h000000, 1'b1, 1'b1, 24'h000000, 1'b1},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h000000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h000100, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_WRITE, skng_pkg::REG_THRESHOLD, 32'h1, 24'h0, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h000002, 1'b0, 1'b0, 24'h0, 1'b0},
            // A new floor must not jump the smoothed gain.
            '{ROW_WRITE, skng_pkg::REG_FLOOR_GAIN, 32'h0, 24'h0, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h7FFFFF, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_WRITE, 3'(REG_UNMAPPED_LO), 32'hFFFFFFFF, 24'h0, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_WRITE, 3'(REG_UNMAPPED_HI), 32'hFFFFFFFF, 24'h0, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_WRITE, skng_pkg::REG_ENV_RELEASE, 32'h0000FFFF, 24'h0, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_WRITE, skng_pkg::REG_GAIN_ATTACK, 32'h0, 24'h0, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_WRITE, skng_pkg::REG_GAIN_RELEASE, 32'h0000FFFF, 24'h0, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_WRITE, skng_pkg::REG_THRESHOLD, 32'h007FFFFF, 24'h0, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'hC00000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_ITEM, 3'd0, 32'h0, 24'h7FFFFF, 1'b0, 1'b0, 24'h0, 1'b0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_ROWS; k++) begin
            if (steps[k].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(int'(steps[k].idx), steps[k].value);
            end else begin
                send_sample(steps[k].sample, steps[k].inv, steps[k].typed,
                            {steps[k].exp_sample, steps[k].exp_passed});
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            // One phase runs with no idling on either side.
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            amp = $urandom_range(1, 8388607);
            case ($urandom_range(0, 5))
                0: thr_v = $urandom_range(0, 3);
                1: thr_v = 8388607;
                2: thr_v = $urandom_range(0, 8388607);
                default: begin
                    thr_v = $urandom_range(amp / 4 + 2, amp + 2);
                    if (thr_v > 8388607) thr_v = 8388607;
                end
            endcase
            write_reg(skng_pkg::REG_THRESHOLD, add_junk(32'(thr_v), 23));
            case ($urandom_range(0, 5))
                0: val = 32'd0;
                1: val = 32'd65536;
                2: val = $urandom_range(65537, 131071);
                default: val = $urandom_range(0, 45000);
            endcase
            write_reg(skng_pkg::REG_FLOOR_GAIN, add_junk(val, 17));
            write_reg(skng_pkg::REG_ENV_ATTACK, pick_coef());
            write_reg(skng_pkg::REG_ENV_RELEASE, pick_coef());
            write_reg(skng_pkg::REG_GAIN_ATTACK, pick_coef());
            write_reg(skng_pkg::REG_GAIN_RELEASE, pick_coef());

            loud = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Loud and quiet bursts push the envelope back and forth across the knee.
                if (n % 20 == 0) loud = $urandom_range(0, 1);
                lim = loud ? amp : amp / 8 + 1;
                pick = $urandom_range(0, 99);
                inv = 1'b0;
                if (pick < 3) begin
                    inv = 1'b1;
                    smp = SMP_W'($urandom);
                end else if (pick < 8) begin
                    smp = ($urandom_range(0, 1) == 1) ? 24'h7FFFFF : 24'h800000;
                end else if (pick < 15) begin
                    smp = SMP_W'($urandom);
                end else if (pick < 22) begin
                    smp = SMP_W'(int'($urandom_range(0, 6)) - 3);
                end else begin
                    smp = SMP_W'(int'($urandom_range(0, 2 * lim)) - lim);
                end
                send_sample(smp, inv, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_gated.size() == 0) begin
            $display("soft_knee_noise_gate_unit_tb: clean");
        end else begin
            $display("soft_knee_noise_gate_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/skng_pkg.sv
src/skng_mul.sv
src/skng_div.sv
src/skng_cfg.sv
src/soft_knee_noise_gate_unit.sv
tb/sv/soft_knee_noise_gate_unit_tb.sv
